>>> hdl/roi_box_denormalizer_assert.svh
`ifndef ROI_BOX_DENORMALIZER_ASSERT_SVH
`define ROI_BOX_DENORMALIZER_ASSERT_SVH

// same-cycle implication on clk, off while in reset
`define RBD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on clk, off while in reset
`define RBD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rbd_pkg.sv
`timescale 1ns / 1ps
package rbd_pkg;

  localparam int CFG_IDX_BITS = 3;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_COEF_XX  = 3'd0,
    CFG_COEF_XY  = 3'd1,
    CFG_COEF_XT  = 3'd2,
    CFG_COEF_YX  = 3'd3,
    CFG_COEF_YY  = 3'd4,
    CFG_COEF_YT  = 3'd5,
    CFG_FRAME_W  = 3'd6,
    CFG_FRAME_H  = 3'd7
  } cfg_reg_t;

  localparam int TUSER_BITS   = 2;
  localparam int TU_TRANSFORM = 0;
  localparam int TU_PARENT    = 1;

endpackage

>>> hdl/roi_box_denormalizer.sv
// Detection box denormalizer: optional 2x3 affine on both corners, clamp to [0,1],
// scale to pixels against the frame or a parent ROI, renormalize parent boxes against the frame.
// Channels: in_* carries one box per transaction (corners and parent ROI in tdata,
// transform/parent flags in tuser); out_* carries the pixel box and the updated
// normalized box; cfg_* writes one register per transaction and is always ready.
// Pipeline: four arithmetic stages, a divider entry stage, FRAC_BITS+1 restoring-divider
// stages (one quotient bit each, four lanes in parallel) and the output register.
// Throughput: one box per cycle while the receiver does not stall; the divider pipeline
// sets the depth, not the rate.
// Reset: pipeline empties, coefficients return to identity, frame to 1920x1080.
// Receiver stall: the output register holds its transaction; earlier stages keep
// filling empty slots, and in_tready drops only once every stage holds a box.
// Registers may be rewritten only while no box is in flight.
`timescale 1ns / 1ps
`include "roi_box_denormalizer_assert.svh"
module roi_box_denormalizer #(
  parameter int FRAC_BITS = 16,
  parameter int DIM_BITS  = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rbd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [FRAC_BITS+7:0]                cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // in_x_min, in_y_min, in_x_max, in_y_max, parent_x, parent_y, parent_w, parent_h
  input  logic [((4*(FRAC_BITS+4)+4*DIM_BITS+7)/8)*8-1:0] in_tdata,
  // has_transform, has_parent
  input  logic [rbd_pkg::TUSER_BITS-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // roi_x, roi_y, roi_w, roi_h, out_x_min, out_y_min, out_x_max, out_y_max
  output logic [((2*(DIM_BITS+1)+2*DIM_BITS+4*(FRAC_BITS+1)+7)/8)*8-1:0] out_tdata
);
  import rbd_pkg::*;

  localparam int IW     = FRAC_BITS + 4;
  localparam int CW     = FRAC_BITS + 8;
  localparam int NB     = FRAC_BITS + 1;
  localparam int QB     = FRAC_BITS + 1;
  localparam int PW     = DIM_BITS + 1;
  localparam int PRW    = 2 * FRAC_BITS + 12;
  localparam int AW     = 2 * FRAC_BITS + 14;
  localparam int TW     = AW - FRAC_BITS;
  localparam int PXW    = FRAC_BITS + DIM_BITS + 1;
  localparam int PSW    = FRAC_BITS + DIM_BITS + 3;
  localparam int ZW     = DIM_BITS + 3;
  localparam int SW     = DIM_BITS + 2;
  localparam int NW     = DIM_BITS + FRAC_BITS + 3;
  localparam int OUT_RAW = 2 * PW + 2 * DIM_BITS + 4 * NB;
  localparam int OUT_DW = ((OUT_RAW + 7) / 8) * 8;
  localparam int DIV0   = 4;
  localparam int NS     = QB + 6;

  localparam logic signed [AW-1:0] HALF_A =
    {{(AW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic [PXW-1:0] HALF_P = {{(PXW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [PSW-1:0] HALF_S =
    {{(PSW-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
  localparam logic signed [TW-1:0] ONE_T = {{(TW-NB){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [NB-1:0] ONE_N = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [CW-1:0] COEF_ONE = {{(CW-NB){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [PW-1:0] POS_MAX = '1;
  localparam logic [DIM_BITS-1:0] DIM_MAX = '1;

  typedef struct packed {
    logic [DIM_BITS:0] rem;
    logic [QB-1:0]     low;
    logic [QB-1:0]     q;
    logic              ovf;
  } lane_t;

  typedef struct packed {
    logic                par;
    logic [NB-1:0]       cy1;
    logic [NB-1:0]       cx1;
    logic [NB-1:0]       cy0;
    logic [NB-1:0]       cx0;
    logic [DIM_BITS-1:0] rh;
    logic [DIM_BITS-1:0] rw;
    logic [PW-1:0]       ry;
    logic [PW-1:0]       rx;
  } pay_t;

  typedef struct packed {
    logic [NB-1:0]       ny1;
    logic [NB-1:0]       nx1;
    logic [NB-1:0]       ny0;
    logic [NB-1:0]       nx0;
    logic [DIM_BITS-1:0] rh;
    logic [DIM_BITS-1:0] rw;
    logic [PW-1:0]       ry;
    logic [PW-1:0]       rx;
  } out_t;

  // configuration
  logic signed [CW-1:0] coef_a_r [2];
  logic signed [CW-1:0] coef_b_r [2];
  logic signed [CW-1:0] coef_t_r [2];
  logic [DIM_BITS-1:0]  frame_r [2];
  logic [DIM_BITS-1:0]  dvs [2];

  // handshake
  logic [NS-1:0] vld_r;
  logic [NS:0]   en;

  // input unpack
  logic signed [IW-1:0] in_crd [4];
  logic [DIM_BITS-1:0]  in_pofs [2];
  logic [DIM_BITS-1:0]  in_psz [2];

  // stage 1: products
  logic signed [PRW-1:0] s1_pa_r [4];
  logic signed [PRW-1:0] s1_pb_r [4];
  logic signed [IW-1:0]  s1_crd_r [4];
  logic                  s1_tr_r;
  logic                  s1_par_r;
  logic [DIM_BITS-1:0]   s1_pofs_r [2];
  logic [DIM_BITS-1:0]   s1_psz_r [2];

  // stage 2: sums and clamp
  logic signed [AW-1:0] s2_acc [4];
  logic signed [TW-1:0] s2_v [4];
  logic [NB-1:0]        s2_c_nxt [4];
  logic [NB-1:0]        s2_c_r [4];
  logic                 s2_par_r;
  logic [DIM_BITS-1:0]  s2_pofs_r [2];
  logic [DIM_BITS-1:0]  s2_psz_r [2];

  // stage 3: pixel scaling products
  logic [DIM_BITS-1:0]   s3_sz [2];
  logic signed [NB:0]    s3_dd [2];
  logic [PXW-1:0]        s3_pp_r [2];
  logic signed [PSW-1:0] s3_ps_r [2];
  logic [DIM_BITS-1:0]   s3_ofs_r [2];
  logic [NB-1:0]         s3_c_r [4];
  logic                  s3_par_r;

  // stage 4: pixel rounding and saturation
  logic [PW-1:0]         s4_pos [2];
  logic [SW-1:0]         s4_tot [2];
  logic signed [PSW-1:0] s4_e [2];
  logic signed [ZW-1:0]  s4_szs [2];
  logic [PW-1:0]         s4_rpos_nxt [2];
  logic [DIM_BITS-1:0]   s4_rsz_nxt [2];
  logic [PW-1:0]         s4_rpos_r [2];
  logic [DIM_BITS-1:0]   s4_rsz_r [2];
  logic [SW-1:0]         s4_pend_r [2];
  logic [NB-1:0]         s4_c_r [4];
  logic                  s4_par_r;

  // divider
  lane_t         lane_nxt [4];
  lane_t         step_nxt [QB][4];
  lane_t         lane_r [QB+1][4];
  pay_t          pay_nxt;
  pay_t          pay_r [QB+1];
  logic [NW-1:0] dv_n [4];
  logic [SW-1:0] dv_p [4];
  logic [SW-1:0] st_t [QB][4];

  // output
  logic [NB-1:0] qf [4];
  out_t          out_nxt;
  out_t          out_r;
  logic          out_par_r;

  assign cfg_ready  = 1'b1;
  assign in_tready  = en[0];
  assign out_tvalid = vld_r[NS-1];
  assign out_tdata  = OUT_DW'(out_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r[0] <= COEF_ONE;
      coef_b_r[0] <= '0;
      coef_t_r[0] <= '0;
      coef_a_r[1] <= '0;
      coef_b_r[1] <= COEF_ONE;
      coef_t_r[1] <= '0;
      frame_r[0]  <= DIM_BITS'(1920);
      frame_r[1]  <= DIM_BITS'(1080);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_COEF_XX: coef_a_r[0] <= cfg_data;
        CFG_COEF_XY: coef_b_r[0] <= cfg_data;
        CFG_COEF_XT: coef_t_r[0] <= cfg_data;
        CFG_COEF_YX: coef_a_r[1] <= cfg_data;
        CFG_COEF_YY: coef_b_r[1] <= cfg_data;
        CFG_COEF_YT: coef_t_r[1] <= cfg_data;
        CFG_FRAME_W: frame_r[0]  <= cfg_data[DIM_BITS-1:0];
        CFG_FRAME_H: frame_r[1]  <= cfg_data[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // zero frame divides by one
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      dvs[a] = (frame_r[a] == '0) ? DIM_BITS'(1) : frame_r[a];
    end
  end

  // stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[NS] = out_tready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      in_crd[j] = in_tdata[j*IW +: IW];
    end
    for (int a = 0; a < 2; a++) begin
      in_pofs[a] = in_tdata[4*IW + a*DIM_BITS +: DIM_BITS];
      in_psz[a]  = in_tdata[4*IW + (a+2)*DIM_BITS +: DIM_BITS];
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 2; k++) begin
        for (int a = 0; a < 2; a++) begin
          s1_pa_r[2*k+a] <= PRW'(in_crd[2*k]) * PRW'(coef_a_r[a]);
          s1_pb_r[2*k+a] <= PRW'(in_crd[2*k+1]) * PRW'(coef_b_r[a]);
        end
      end
      for (int j = 0; j < 4; j++) begin
        s1_crd_r[j] <= in_crd[j];
      end
      for (int a = 0; a < 2; a++) begin
        s1_pofs_r[a] <= in_pofs[a];
        s1_psz_r[a]  <= in_psz[a];
      end
      s1_tr_r  <= in_tuser[TU_TRANSFORM];
      s1_par_r <= in_tuser[TU_PARENT];
    end
  end

  // stage 2
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      for (int a = 0; a < 2; a++) begin
        s2_acc[2*k+a] = AW'(s1_pa_r[2*k+a]) + AW'(s1_pb_r[2*k+a])
                      + (AW'(coef_t_r[a]) <<< FRAC_BITS) + HALF_A;
      end
    end
    for (int j = 0; j < 4; j++) begin
      s2_v[j] = s1_tr_r ? TW'(s2_acc[j] >>> FRAC_BITS) : TW'(s1_crd_r[j]);
      if (s2_v[j][TW-1]) begin
        s2_c_nxt[j] = '0;
      end else if (s2_v[j] > ONE_T) begin
        s2_c_nxt[j] = ONE_N;
      end else begin
        s2_c_nxt[j] = s2_v[j][NB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int j = 0; j < 4; j++) begin
        s2_c_r[j] <= s2_c_nxt[j];
      end
      for (int a = 0; a < 2; a++) begin
        s2_pofs_r[a] <= s1_pofs_r[a];
        s2_psz_r[a]  <= s1_psz_r[a];
      end
      s2_par_r <= s1_par_r;
    end
  end

  // stage 3
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      s3_sz[a] = s2_par_r ? s2_psz_r[a] : frame_r[a];
      s3_dd[a] = $signed({1'b0, s2_c_r[a+2]}) - $signed({1'b0, s2_c_r[a]});
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int a = 0; a < 2; a++) begin
        s3_pp_r[a]  <= PXW'(s2_c_r[a]) * PXW'(s3_sz[a]);
        s3_ps_r[a]  <= PSW'(s3_dd[a]) * PSW'($signed({1'b0, s3_sz[a]}));
        s3_ofs_r[a] <= s2_par_r ? s2_pofs_r[a] : '0;
      end
      for (int j = 0; j < 4; j++) begin
        s3_c_r[j] <= s2_c_r[j];
      end
      s3_par_r <= s2_par_r;
    end
  end

  // stage 4
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      s4_pos[a] = PW'((s3_pp_r[a] + HALF_P) >> FRAC_BITS);
      s4_tot[a] = SW'(s4_pos[a]) + SW'(s3_ofs_r[a]);
      s4_rpos_nxt[a] = (s4_tot[a] > SW'(POS_MAX)) ? POS_MAX : s4_tot[a][PW-1:0];
      s4_e[a]   = s3_ps_r[a] + HALF_S;
      s4_szs[a] = ZW'(s4_e[a] >>> FRAC_BITS);
      if (s4_szs[a][ZW-1]) begin
        s4_rsz_nxt[a] = '0;
      end else if (s4_szs[a][ZW-2:DIM_BITS] != '0) begin
        s4_rsz_nxt[a] = DIM_MAX;
      end else begin
        s4_rsz_nxt[a] = s4_szs[a][DIM_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int a = 0; a < 2; a++) begin
        s4_rpos_r[a] <= s4_rpos_nxt[a];
        s4_rsz_r[a]  <= s4_rsz_nxt[a];
        s4_pend_r[a] <= SW'(s4_rpos_nxt[a]) + SW'(s4_rsz_nxt[a]);
      end
      for (int j = 0; j < 4; j++) begin
        s4_c_r[j] <= s3_c_r[j];
      end
      s4_par_r <= s3_par_r;
    end
  end

  // divider entry: numerator = pix * 2^F + frame/2, overflow when quotient >= 2^QB
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      for (int a = 0; a < 2; a++) begin
        dv_p[2*k+a] = (k == 0) ? SW'(s4_rpos_r[a]) : s4_pend_r[a];
        dv_n[2*k+a] = (NW'(dv_p[2*k+a]) << FRAC_BITS) + NW'(dvs[a] >> 1);
        lane_nxt[2*k+a].ovf = dv_n[2*k+a] >= (NW'(dvs[a]) << QB);
        lane_nxt[2*k+a].rem = dv_n[2*k+a][QB +: DIM_BITS+1];
        lane_nxt[2*k+a].low = dv_n[2*k+a][QB-1:0];
        lane_nxt[2*k+a].q   = '0;
      end
    end
    pay_nxt.par = s4_par_r;
    pay_nxt.cx0 = s4_c_r[0];
    pay_nxt.cy0 = s4_c_r[1];
    pay_nxt.cx1 = s4_c_r[2];
    pay_nxt.cy1 = s4_c_r[3];
    pay_nxt.rx  = s4_rpos_r[0];
    pay_nxt.ry  = s4_rpos_r[1];
    pay_nxt.rw  = s4_rsz_r[0];
    pay_nxt.rh  = s4_rsz_r[1];
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    for (int s = 0; s < QB; s++) begin
      for (int k = 0; k < 2; k++) begin
        for (int a = 0; a < 2; a++) begin
          st_t[s][2*k+a] = {lane_r[s][2*k+a].rem, lane_r[s][2*k+a].low[QB-1]};
          step_nxt[s][2*k+a].ovf = lane_r[s][2*k+a].ovf;
          step_nxt[s][2*k+a].low = lane_r[s][2*k+a].low << 1;
          if (st_t[s][2*k+a] >= SW'(dvs[a])) begin
            step_nxt[s][2*k+a].rem = PW'(st_t[s][2*k+a] - SW'(dvs[a]));
            step_nxt[s][2*k+a].q   = {lane_r[s][2*k+a].q[QB-2:0], 1'b1};
          end else begin
            step_nxt[s][2*k+a].rem = st_t[s][2*k+a][DIM_BITS:0];
            step_nxt[s][2*k+a].q   = {lane_r[s][2*k+a].q[QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[DIV0]) begin
      for (int j = 0; j < 4; j++) begin
        lane_r[0][j] <= lane_nxt[j];
      end
      pay_r[0] <= pay_nxt;
    end
    for (int s = 0; s < QB; s++) begin
      if (en[DIV0+s+1]) begin
        for (int j = 0; j < 4; j++) begin
          lane_r[s+1][j] <= step_nxt[s][j];
        end
        pay_r[s+1] <= pay_r[s];
      end
    end
  end

  // output register
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      qf[j] = (lane_r[QB][j].ovf || lane_r[QB][j].q > ONE_N) ? ONE_N : lane_r[QB][j].q;
    end
    out_nxt.rx  = pay_r[QB].rx;
    out_nxt.ry  = pay_r[QB].ry;
    out_nxt.rw  = pay_r[QB].rw;
    out_nxt.rh  = pay_r[QB].rh;
    out_nxt.nx0 = pay_r[QB].par ? qf[0] : pay_r[QB].cx0;
    out_nxt.ny0 = pay_r[QB].par ? qf[1] : pay_r[QB].cy0;
    out_nxt.nx1 = pay_r[QB].par ? qf[2] : pay_r[QB].cx1;
    out_nxt.ny1 = pay_r[QB].par ? qf[3] : pay_r[QB].cy1;
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      out_r     <= out_nxt;
      out_par_r <= pay_r[QB].par;
    end
  end

  `RBD_ASSERT_IMPL(a_in_stall, !in_tready, out_tvalid && !out_tready,
    "input stalled while the pipeline had room")
  `RBD_ASSERT_NEXT(a_refill, out_tvalid && out_tready && vld_r[NS-2], out_tvalid,
    "output register not refilled behind an accepted transaction")
  `RBD_ASSERT_IMPL(a_div_rem, vld_r[NS-2] && !lane_r[QB][0].ovf,
    lane_r[QB][0].rem < PW'(dvs[0]), "divider remainder not below divisor")
  `RBD_ASSERT_IMPL(a_box_order, out_tvalid && !out_par_r && out_r.rw != '0,
    out_r.nx1 > out_r.nx0, "nonzero width from an inverted box")

endmodule

>>> tb/roi_box_denormalizer_test.sv
`timescale 1ns / 1ps
module roi_box_denormalizer_test;
  import rbd_pkg::*;

  localparam longint UNIT     = 64'sd65536;
  localparam longint HALF     = 64'sd32768;
  localparam longint POS_MAX  = 64'sd32767;
  localparam longint DIM_MAX  = 64'sd16383;
  localparam int     IN_MIN   = -524288;
  localparam int     IN_MAX   = 524287;
  localparam int     U        = 65536;
  localparam int     N_DIR    = 18;
  localparam int     N_PHASES = 7;
  localparam int     WATCHDOG = 5000;
  localparam int     HOLD_OFF = 300;

  typedef struct packed {
    logic signed [19:0] x_min;
    logic signed [19:0] y_min;
    logic signed [19:0] x_max;
    logic signed [19:0] y_max;
    logic               transform;
    logic               parent;
    logic [13:0]        px;
    logic [13:0]        py;
    logic [13:0]        pw;
    logic [13:0]        ph;
  } box_t;

  // last member sits in the lowest bits, matching out_tdata
  typedef struct packed {
    logic [16:0] ny_max;
    logic [16:0] nx_max;
    logic [16:0] ny_min;
    logic [16:0] nx_min;
    logic [13:0] roi_h;
    logic [13:0] roi_w;
    logic [14:0] roi_y;
    logic [14:0] roi_x;
  } roi_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [23:0]  cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  // in_x_min, in_y_min, in_x_max, in_y_max, parent_x, parent_y, parent_w, parent_h
  logic [135:0] in_tdata = '0;
  // has_transform, has_parent
  logic [TUSER_BITS-1:0] in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  // roi_x, roi_y, roi_w, roi_h, out_x_min, out_y_min, out_x_max, out_y_max
  logic [127:0] out_tdata;

  logic [23:0] cfg_shadow [8];
  logic [23:0] next_regs [8];
  roi_t        pending_rois [$];

  int fail_cnt = 0;
  int n_sent = 0;
  int n_checked = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req_cnt = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  box_t dir_box [N_DIR];
  bit   dir_typed [N_DIR];
  roi_t dir_roi [N_DIR];

  roi_box_denormalizer i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint affine_round(longint a, longint b, longint ca, longint cb,
                                          longint ct);
    longint acc;
    acc = a * ca + b * cb + ct * UNIT;
    return (acc + HALF) >>> 16;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > UNIT) return UNIT;
    return v;
  endfunction

  function automatic longint pixel_round(longint coord, longint size);
    return (coord * size + HALF) >>> 16;
  endfunction

  function automatic longint sat_to(longint v, longint maxv);
    if (v < 0) return 0;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic longint renorm(longint pix, longint frame);
    longint d, q;
    d = (frame == 0) ? 1 : frame;
    q = ((pix <<< 16) + d / 2) / d;
    return (q > UNIT) ? UNIT : q;
  endfunction

  function automatic roi_t predict_roi(box_t b);
    longint x0, y0, x1, y1, ta, tb, tc, td;
    longint fw, fh, sw, sh, ox, oy, rx, ry, rw, rh;
    longint cxx, cxy, cxt, cyx, cyy, cyt;
    roi_t r;
    x0 = 64'(b.x_min);
    y0 = 64'(b.y_min);
    x1 = 64'(b.x_max);
    y1 = 64'(b.y_max);
    cxx = 64'($signed(cfg_shadow[CFG_COEF_XX]));
    cxy = 64'($signed(cfg_shadow[CFG_COEF_XY]));
    cxt = 64'($signed(cfg_shadow[CFG_COEF_XT]));
    cyx = 64'($signed(cfg_shadow[CFG_COEF_YX]));
    cyy = 64'($signed(cfg_shadow[CFG_COEF_YY]));
    cyt = 64'($signed(cfg_shadow[CFG_COEF_YT]));
    fw = 64'(cfg_shadow[CFG_FRAME_W][13:0]);
    fh = 64'(cfg_shadow[CFG_FRAME_H][13:0]);
    if (b.transform) begin
      ta = affine_round(x0, y0, cxx, cxy, cxt);
      tb = affine_round(x0, y0, cyx, cyy, cyt);
      tc = affine_round(x1, y1, cxx, cxy, cxt);
      td = affine_round(x1, y1, cyx, cyy, cyt);
      x0 = ta; y0 = tb; x1 = tc; y1 = td;
    end
    x0 = clamp_unit(x0);
    y0 = clamp_unit(y0);
    x1 = clamp_unit(x1);
    y1 = clamp_unit(y1);
    if (b.parent) begin
      sw = 64'(b.pw); sh = 64'(b.ph); ox = 64'(b.px); oy = 64'(b.py);
    end else begin
      sw = fw; sh = fh; ox = 0; oy = 0;
    end
    rx = sat_to(pixel_round(x0, sw) + ox, POS_MAX);
    ry = sat_to(pixel_round(y0, sh) + oy, POS_MAX);
    rw = sat_to(pixel_round(x1 - x0, sw), DIM_MAX);
    rh = sat_to(pixel_round(y1 - y0, sh), DIM_MAX);
    r.roi_x = rx[14:0];
    r.roi_y = ry[14:0];
    r.roi_w = rw[13:0];
    r.roi_h = rh[13:0];
    if (b.parent) begin
      r.nx_min = 17'(renorm(rx, fw));
      r.ny_min = 17'(renorm(ry, fh));
      r.nx_max = 17'(renorm(rx + rw, fw));
      r.ny_max = 17'(renorm(ry + rh, fh));
    end else begin
      r.nx_min = x0[16:0];
      r.ny_min = y0[16:0];
      r.nx_max = x1[16:0];
      r.ny_max = y1[16:0];
    end
    return r;
  endfunction

  function automatic box_t mk_box(int x0, int y0, int x1, int y1, bit tr, bit par,
                                  int px, int py, int pw, int ph);
    box_t b;
    b.x_min = 20'(x0); b.y_min = 20'(y0); b.x_max = 20'(x1); b.y_max = 20'(y1);
    b.transform = tr; b.parent = par;
    b.px = 14'(px); b.py = 14'(py); b.pw = 14'(pw); b.ph = 14'(ph);
    return b;
  endfunction

  function automatic roi_t mk_roi(int rx, int ry, int rw, int rh, int n0, int n1, int n2,
                                  int n3);
    roi_t r;
    r.roi_x = 15'(rx); r.roi_y = 15'(ry); r.roi_w = 14'(rw); r.roi_h = 14'(rh);
    r.nx_min = 17'(n0); r.ny_min = 17'(n1); r.nx_max = 17'(n2); r.ny_max = 17'(n3);
    return r;
  endfunction

  function automatic int rand_coord(int sel);
    if (sel < 85) return int'($urandom_range(0, 3 * U / 2)) - U / 4;
    return int'($urandom() & 32'hFFFFF);
  endfunction

  function automatic box_t random_box();
    box_t b;
    int sel, lo, hi;
    sel = $urandom_range(99);
    if (sel < 70) begin
      lo = $urandom_range(0, U);
      hi = $urandom_range(lo, U);
      b.x_min = 20'(lo); b.x_max = 20'(hi);
      lo = $urandom_range(0, U);
      hi = $urandom_range(lo, U);
      b.y_min = 20'(lo); b.y_max = 20'(hi);
    end else begin
      b.x_min = 20'(rand_coord(sel));
      b.y_min = 20'(rand_coord(sel));
      b.x_max = 20'(rand_coord(sel));
      b.y_max = 20'(rand_coord(sel));
    end
    b.transform = 1'($urandom_range(1));
    b.parent = 1'($urandom_range(1));
    if ($urandom_range(3) == 0) begin
      b.px = 14'($urandom()); b.py = 14'($urandom());
      b.pw = 14'($urandom()); b.ph = 14'($urandom());
    end else begin
      b.px = 14'($urandom_range(0, 2047));
      b.py = 14'($urandom_range(0, 2047));
      b.pw = 14'($urandom_range(0, 1023));
      b.ph = 14'($urandom_range(0, 1023));
    end
    return b;
  endfunction

  task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_shadow[idx] = val;
  endtask

  task automatic apply_regs();
    for (int i = 0; i < 8; i++) write_reg(cfg_reg_t'(i), next_regs[i]);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_box(box_t b, bit typed, roi_t want);
    logic [TUSER_BITS-1:0] tu;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    tu = '0;
    tu[TU_TRANSFORM] = b.transform;
    tu[TU_PARENT]    = b.parent;
    in_tvalid <= 1'b1;
    in_tdata  <= {b.ph, b.pw, b.py, b.px, b.y_max, b.x_max, b.y_min, b.x_min};
    in_tuser  <= tu;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_rois.insert(pending_rois.size(), typed ? want : predict_roi(b));
    n_sent++;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    roi_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = roi_t'(out_tdata[125:0]);
      if (pending_rois.size() == 0) begin
        $error("result transaction with no box outstanding");
        fail_cnt++;
      end else begin
        want = pending_rois[0];
        pending_rois.delete(0);
        check_field("roi_x", 32'(want.roi_x), 32'(got.roi_x));
        check_field("roi_y", 32'(want.roi_y), 32'(got.roi_y));
        check_field("roi_w", 32'(want.roi_w), 32'(got.roi_w));
        check_field("roi_h", 32'(want.roi_h), 32'(got.roi_h));
        check_field("out_x_min", 32'(want.nx_min), 32'(got.nx_min));
        check_field("out_y_min", 32'(want.ny_min), 32'(got.ny_min));
        check_field("out_x_max", 32'(want.nx_max), 32'(got.nx_max));
        check_field("out_y_max", 32'(want.ny_max), 32'(got.ny_max));
        n_checked++;
      end
    end
    if (hold_seen != hold_req_cnt) begin
      hold_seen = hold_req_cnt;
      hold_left = HOLD_OFF;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    cfg_shadow[CFG_COEF_XX] = 24'd65536;
    cfg_shadow[CFG_COEF_XY] = '0;
    cfg_shadow[CFG_COEF_XT] = '0;
    cfg_shadow[CFG_COEF_YX] = '0;
    cfg_shadow[CFG_COEF_YY] = 24'd65536;
    cfg_shadow[CFG_COEF_YT] = '0;
    cfg_shadow[CFG_FRAME_W] = 24'd1920;
    cfg_shadow[CFG_FRAME_H] = 24'd1080;

    dir_typed = '{default: 1'b0};
    dir_roi   = '{default: '0};
    dir_box[0]  = mk_box(0, 0, U, U, 0, 0, 0, 0, 0, 0);
    dir_typed[0] = 1'b1; dir_roi[0] = mk_roi(0, 0, 1920, 1080, 0, 0, U, U);
    dir_box[1]  = mk_box(IN_MIN, IN_MIN, IN_MIN, IN_MIN, 0, 0, 0, 0, 0, 0);
    dir_typed[1] = 1'b1; dir_roi[1] = mk_roi(0, 0, 0, 0, 0, 0, 0, 0);
    dir_box[2]  = mk_box(IN_MAX, IN_MAX, IN_MAX, IN_MAX, 0, 0, 0, 0, 0, 0);
    dir_typed[2] = 1'b1; dir_roi[2] = mk_roi(1920, 1080, 0, 0, U, U, U, U);
    dir_box[3]  = mk_box(U / 4, U / 4, 3 * U / 4, 3 * U / 4, 0, 0, 0, 0, 0, 0);
    // inverted box, width and height go to zero
    dir_box[4]  = mk_box(3 * U / 4, 3 * U / 4, U / 4, U / 4, 0, 0, 0, 0, 0, 0);
    dir_box[5]  = mk_box(U / 10, U / 5, 9 * U / 10, 4 * U / 5, 1, 0, 0, 0, 0, 0);
    dir_box[6]  = mk_box(-U / 2, -U / 4, U / 2, 2 * U, 1, 0, 0, 0, 0, 0);
    dir_box[7]  = mk_box(IN_MIN, IN_MAX, IN_MIN, IN_MAX, 1, 0, 0, 0, 0, 0);
    // half-pixel tie rounds up
    dir_box[8]  = mk_box(U / 2, U / 2, U, U, 0, 1, 0, 0, 3, 3);
    dir_box[9]  = mk_box(0, 0, U, U, 0, 1, 100, 200, 640, 480);
    dir_box[10] = mk_box(0, 0, U, U, 0, 1, 16383, 16383, 16383, 16383);
    dir_typed[10] = 1'b1; dir_roi[10] = mk_roi(16383, 16383, 16383, 16383, U, U, U, U);
    dir_box[11] = mk_box(U, U, U, U, 0, 1, 16383, 16383, 16383, 16383);
    // zero-sized parent at an offset
    dir_box[12] = mk_box(U / 3, U / 3, 2 * U / 3, 2 * U / 3, 0, 1, 50, 60, 0, 0);
    dir_box[13] = mk_box(0, 0, U, U, 0, 1, 0, 0, 0, 0);
    dir_typed[13] = 1'b1; dir_roi[13] = mk_roi(0, 0, 0, 0, 0, 0, 0, 0);
    dir_box[14] = mk_box(20'hAAAAA, 20'h55555, 20'h55555, 20'hAAAAA, 1, 1,
                         14'h2AAA, 14'h1555, 14'h2AAA, 14'h1555);
    dir_box[15] = mk_box(20'h55555, 20'hAAAAA, 20'hAAAAA, 20'h55555, 0, 1,
                         14'h1555, 14'h2AAA, 14'h1555, 14'h2AAA);
    dir_box[16] = mk_box(U, 0, 0, U, 1, 1, 1, 1, 1, 1);
    dir_box[17] = mk_box(U + 1, -1, U + 1, -1, 0, 0, 0, 0, 0, 0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) send_box(dir_box[i], dir_typed[i], dir_roi[i]);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph > 0) begin
        in_tvalid <= 1'b0;
        while (pending_rois.size() != 0) @(posedge clk);
        case (ph)
          1, 6: begin
            next_regs[CFG_COEF_XX] = 24'($urandom_range(U / 2, 3 * U / 2));
            next_regs[CFG_COEF_XY] = 24'(int'($urandom_range(0, U / 2)) - U / 4);
            next_regs[CFG_COEF_XT] = 24'(int'($urandom_range(0, U / 2)) - U / 4);
            next_regs[CFG_COEF_YX] = 24'(int'($urandom_range(0, U / 2)) - U / 4);
            next_regs[CFG_COEF_YY] = 24'($urandom_range(U / 2, 3 * U / 2));
            next_regs[CFG_COEF_YT] = 24'(int'($urandom_range(0, U / 2)) - U / 4);
            next_regs[CFG_FRAME_W] = (ph == 1) ? 24'($urandom_range(1, 16383))
                                               : 24'($urandom_range(1, 64));
            next_regs[CFG_FRAME_H] = (ph == 1) ? 24'($urandom_range(1, 16383))
                                               : 24'($urandom_range(1, 64));
          end
          2: begin
            for (int i = 0; i < 6; i++) next_regs[i] = 24'h7FFFFF;
            next_regs[CFG_FRAME_W] = 24'd16383;
            next_regs[CFG_FRAME_H] = 24'd16383;
          end
          3: begin
            for (int i = 0; i < 6; i++) next_regs[i] = 24'h800000;
            next_regs[CFG_FRAME_W] = 24'd1;
            next_regs[CFG_FRAME_H] = 24'd1;
          end
          4: begin
            // zero frame size: renormalization divides by one
            next_regs[CFG_COEF_XX] = 24'(U);
            next_regs[CFG_COEF_XY] = 24'(U / 8);
            next_regs[CFG_COEF_XT] = 24'(-U / 16);
            next_regs[CFG_COEF_YX] = 24'(-U / 8);
            next_regs[CFG_COEF_YY] = 24'(U);
            next_regs[CFG_COEF_YT] = 24'(U / 16);
            next_regs[CFG_FRAME_W] = '0;
            next_regs[CFG_FRAME_H] = '0;
          end
          default: begin
            for (int i = 0; i < 6; i++) next_regs[i] = 24'($urandom());
            next_regs[CFG_FRAME_W] = 24'($urandom_range(1, 16383));
            next_regs[CFG_FRAME_H] = 24'($urandom_range(1, 16383));
          end
        endcase
        apply_regs();
      end
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      if (ph == 0) hold_req_cnt++;
      repeat (100) send_box(random_box(), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (pending_rois.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d boxes (%0d directed) across %0d register settings and four idle mixes,",
             n_sent, N_DIR, N_PHASES);
    $display("including a long output hold-off; %0d result transactions compared.", n_checked);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
